// ===== rtl/core/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// shared types, codes and scancode decode functions for the key tracker
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;

  localparam logic [7:0] SC_PREFIX = 8'hE0;
  localparam logic [6:0] SC_MASK7  = 7'h7F;
  localparam logic [6:0] SC_ESC    = 7'h01;

  localparam logic [6:0] SC_MAIN_W = 7'h11;
  localparam logic [6:0] SC_MAIN_S = 7'h1F;
  localparam logic [6:0] SC_MAIN_A = 7'h1E;
  localparam logic [6:0] SC_MAIN_D = 7'h20;
  localparam logic [6:0] SC_MAIN_Q = 7'h10;
  localparam logic [6:0] SC_MAIN_E = 7'h12;

  localparam logic [6:0] SC_EXT_W = 7'h48;
  localparam logic [6:0] SC_EXT_S = 7'h50;
  localparam logic [6:0] SC_EXT_Q = 7'h4B;
  localparam logic [6:0] SC_EXT_E = 7'h4D;

  localparam logic [5:0] KEY_W = 6'b000001;
  localparam logic [5:0] KEY_S = 6'b000010;
  localparam logic [5:0] KEY_A = 6'b000100;
  localparam logic [5:0] KEY_D = 6'b001000;
  localparam logic [5:0] KEY_Q = 6'b010000;
  localparam logic [5:0] KEY_E = 6'b100000;

  typedef enum logic [1:0] {
    CMD_SUBMIT    = 2'd0,
    CMD_POP       = 2'd1,
    CMD_READ_EXIT = 2'd2,
    CMD_SET_EXIT  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] code;
    logic       released;
    logic       is_prefix;
    logic       is_esc;
    logic [5:0] main_bit;
    logic [5:0] ext_bit;
  } cls_t;

  function automatic logic [5:0] main_key(input logic [6:0] code7);
    logic [5:0] bit_v;
    unique case (code7)
      SC_MAIN_W: bit_v = KEY_W;
      SC_MAIN_S: bit_v = KEY_S;
      SC_MAIN_A: bit_v = KEY_A;
      SC_MAIN_D: bit_v = KEY_D;
      SC_MAIN_Q: bit_v = KEY_Q;
      SC_MAIN_E: bit_v = KEY_E;
      default:   bit_v = '0;
    endcase
    return bit_v;
  endfunction

  function automatic logic [5:0] ext_key(input logic [6:0] code7);
    logic [5:0] bit_v;
    unique case (code7)
      SC_EXT_W: bit_v = KEY_W;
      SC_EXT_S: bit_v = KEY_S;
      SC_EXT_Q: bit_v = KEY_Q;
      SC_EXT_E: bit_v = KEY_E;
      default:  bit_v = '0;
    endcase
    return bit_v;
  endfunction

endpackage

// ===== rtl/core/skt_in_if.sv =====
// ----------------------------------------------------------------------------
// skt_in_if
// command channel of the key tracker: valid/ready with command and scancode
// ----------------------------------------------------------------------------
interface skt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] scancode;

  modport source (output valid, output cmd, output scancode, input ready);
  modport sink   (input valid, input cmd, input scancode, output ready);
endinterface

// ===== rtl/core/skt_out_if.sv =====
// ----------------------------------------------------------------------------
// skt_out_if
// result channel of the key tracker: valid/ready with key mask, pop and flag
// ----------------------------------------------------------------------------
interface skt_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] held_keys;
  logic       pop_valid;
  logic [7:0] pop_code;
  logic       exit_flag;

  modport source (output valid, output held_keys, output pop_valid, output pop_code,
                  output exit_flag, input ready);
  modport sink   (input valid, input held_keys, input pop_valid, input pop_code,
                  input exit_flag, output ready);
endinterface

// ===== rtl/core/skt_front.sv =====
// ----------------------------------------------------------------------------
// skt_front
// accepts command transactions and classifies the scancode for the back end
// ----------------------------------------------------------------------------
module skt_front (
  skt_in_if.sink         in_chan,
  input  logic           push_ready,
  output logic           push_valid,
  output skt_pkg::cls_t  push_data
);
  import skt_pkg::*;

  logic [6:0] code7;

  assign code7          = in_chan.scancode[6:0] & SC_MASK7;
  assign in_chan.ready  = push_ready;
  assign push_valid     = in_chan.valid;

  always_comb begin
    push_data.cmd       = cmd_t'(in_chan.cmd);
    push_data.code      = in_chan.scancode;
    push_data.released  = in_chan.scancode[7];
    push_data.is_prefix = (in_chan.scancode == SC_PREFIX);
    push_data.is_esc    = (code7 == SC_ESC);
    push_data.main_bit  = main_key(code7);
    push_data.ext_bit   = ext_key(code7);
  end

endmodule

// ===== rtl/core/skt_fifo.sv =====
// ----------------------------------------------------------------------------
// skt_fifo
// two-entry queue of classified commands between front and back end
// ----------------------------------------------------------------------------
module skt_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  skt_pkg::cls_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output skt_pkg::cls_t  pop_data
);
  import skt_pkg::*;

  cls_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/skt_back.sv =====
// ----------------------------------------------------------------------------
// skt_back
// executes commands: key mask, prefix, exit flag, byte ring and result register
// ----------------------------------------------------------------------------
module skt_back #(
  parameter int unsigned QUEUE_DEPTH = skt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  skt_pkg::cls_t  cmd_data,
  skt_out_if.source      out_chan
);
  import skt_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  logic [7:0]    mem [QUEUE_DEPTH];
  logic [7:0]    rdata_r;

  logic          en_r;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [5:0]    mask_r, mask_nxt;
  logic          prefix_r, prefix_nxt;
  logic          exit_r, exit_nxt;

  logic          out_valid_r;
  logic [5:0]    held_r;
  logic          popv_r, popv_nxt;
  logic          flag_r, flag_nxt;

  logic          fire;
  logic          mem_we, mem_re;
  logic [AW-1:0] wr_inc, rd_inc;
  logic [5:0]    key_bit;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + AW'(1);
  endfunction

  assign cmd_ready = !out_valid_r || out_chan.ready;
  assign fire      = cmd_valid && cmd_ready;
  assign wr_inc    = idx_inc(wr_idx_r);
  assign rd_inc    = idx_inc(rd_idx_r);
  assign key_bit   = prefix_r ? cmd_data.ext_bit : cmd_data.main_bit;

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    mask_nxt   = mask_r;
    prefix_nxt = prefix_r;
    exit_nxt   = exit_r;
    popv_nxt   = 1'b0;
    flag_nxt   = exit_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    if (fire) begin
      unique case (cmd_data.cmd)
        CMD_SUBMIT: begin
          if (en_r) begin
            mem_we     = 1'b1;
            wr_idx_nxt = wr_inc;
            if (wr_inc == rd_idx_r) begin
              rd_idx_nxt = rd_inc;
            end
            if (cmd_data.is_esc) begin
              exit_nxt = 1'b1;
            end
            if (cmd_data.is_prefix) begin
              prefix_nxt = 1'b1;
            end else begin
              prefix_nxt = 1'b0;
              mask_nxt   = cmd_data.released ? (mask_r & ~key_bit) : (mask_r | key_bit);
            end
          end
          flag_nxt = exit_nxt;
        end
        CMD_POP: begin
          if (rd_idx_r != wr_idx_r) begin
            mem_re     = 1'b1;
            popv_nxt   = 1'b1;
            rd_idx_nxt = rd_inc;
          end
        end
        CMD_READ_EXIT: begin
          exit_nxt = 1'b0;
        end
        CMD_SET_EXIT: begin
          exit_nxt = 1'b1;
          flag_nxt = 1'b1;
        end
        default: begin
          exit_nxt = exit_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      mask_r      <= '0;
      prefix_r    <= 1'b0;
      exit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cfg_we) begin
      en_r        <= cfg_wdata;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      mask_r      <= '0;
      prefix_r    <= 1'b0;
      exit_r      <= 1'b0;
    end else begin
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      mask_r      <= mask_nxt;
      prefix_r    <= prefix_nxt;
      exit_r      <= exit_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      held_r <= mask_nxt;
      popv_r <= popv_nxt;
      flag_r <= flag_nxt;
    end
  end

  // byte ring storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx_r] <= cmd_data.code;
    end
    if (mem_re) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.held_keys = held_r;
  assign out_chan.pop_valid = popv_r;
  assign out_chan.pop_code  = popv_r ? rdata_r : 8'h00;
  assign out_chan.exit_flag = flag_r;

endmodule

// ===== rtl/core/scancode_key_tracker.sv =====
// ----------------------------------------------------------------------------
// scancode_key_tracker
// set-1 scancode decoder with held-key mask, exit flag and byte ring queue
// ----------------------------------------------------------------------------
//   channel    direction  handshake     payload
//   in_chan    in         valid/ready   cmd, scancode
//   out_chan   out        valid/ready   held_keys, pop_valid, pop_code, exit_flag
//   cfg_*      in         write enable  cfg_wdata (input enable)
//
// one command per cycle sustained while the result channel is not stalled; a command
// passes the front classify into the two-entry queue, then is executed into the result
// register, with the ring read registered alongside it.
// reset is synchronous and needs no clearing pass; ring entries are only read
// after being written. a stalled result holds; the queue absorbs two commands.
module scancode_key_tracker #(
  parameter int unsigned QUEUE_DEPTH = skt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  skt_in_if.sink     in_chan,
  skt_out_if.source  out_chan
);
  import skt_pkg::*;

  logic push_valid, push_ready;
  cls_t push_data;
  logic cmd_valid, cmd_ready;
  cls_t cmd_data;

  skt_front u_front (
    .in_chan    (in_chan),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  skt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (cmd_valid),
    .pop_ready  (cmd_ready),
    .pop_data   (cmd_data)
  );

  skt_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .out_chan  (out_chan)
  );

endmodule

// ===== rtl/core/skt_checker.sv =====
// ----------------------------------------------------------------------------
// skt_checker
// port-level checks on the key tracker result channel
// ----------------------------------------------------------------------------
module skt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_held_keys,
  input logic       out_pop_valid,
  input logic [7:0] out_pop_code,
  input logic       out_exit_flag
);

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_held_keys) && $stable(out_pop_valid)
                                && $stable(out_pop_code) && $stable(out_exit_flag))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_pop_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pop_valid |-> out_pop_code == 8'h00)
    else $error("pop code nonzero without pop");

endmodule

bind scancode_key_tracker skt_checker u_skt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_held_keys (out_chan.held_keys),
  .out_pop_valid (out_chan.pop_valid),
  .out_pop_code  (out_chan.pop_code),
  .out_exit_flag (out_chan.exit_flag)
);

// ===== verif/skt_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_scoreboard_pkg
// scoreboard for the key tracker: mirrors the ring queue, held-key mask,
// extended prefix and exit flag, and checks each result transaction in order
// ----------------------------------------------------------------------------
package skt_scoreboard_pkg;
  import skt_pkg::*;

  typedef struct {
    logic [5:0] held_keys;
    logic       pop_valid;
    logic [7:0] pop_code;
    logic       exit_flag;
  } key_report_t;

  class tracker_scoreboard;
    logic [7:0]  ring [QUEUE_DEPTH_DEF];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    logic [5:0]  keys;
    logic        prefix_armed;
    logic        exit_latch;
    logic        enabled;
    key_report_t expected_reports[$];
    int unsigned errors;

    function new();
      enabled = 1'b0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      wr_ptr = 0;
      rd_ptr = 0;
      keys = '0;
      prefix_armed = 1'b0;
      exit_latch = 1'b0;
    endfunction

    function void set_enable(logic value);
      enabled = value;
      clear();
    endfunction

    function int unsigned outstanding();
      return expected_reports.size();
    endfunction

    function logic [5:0] decode_key(logic extended, logic [6:0] code7);
      logic [5:0] bit_v;
      bit_v = '0;
      if (extended) begin
        case (code7)
          SC_EXT_W: bit_v = KEY_W;
          SC_EXT_S: bit_v = KEY_S;
          SC_EXT_Q: bit_v = KEY_Q;
          SC_EXT_E: bit_v = KEY_E;
          default:  bit_v = '0;
        endcase
      end else begin
        case (code7)
          SC_MAIN_W: bit_v = KEY_W;
          SC_MAIN_S: bit_v = KEY_S;
          SC_MAIN_A: bit_v = KEY_A;
          SC_MAIN_D: bit_v = KEY_D;
          SC_MAIN_Q: bit_v = KEY_Q;
          SC_MAIN_E: bit_v = KEY_E;
          default:   bit_v = '0;
        endcase
      end
      return bit_v;
    endfunction

    function void take_scancode(logic [7:0] code);
      int unsigned next_ptr;
      logic [5:0]  bit_v;
      if (!enabled) return;
      if (code[6:0] == SC_ESC) exit_latch = 1'b1;
      next_ptr = (wr_ptr + 1) % QUEUE_DEPTH_DEF;
      if (next_ptr == rd_ptr) rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH_DEF;
      ring[wr_ptr] = code;
      wr_ptr = next_ptr;
      if (code == SC_PREFIX) begin
        prefix_armed = 1'b1;
        return;
      end
      bit_v = decode_key(prefix_armed, code[6:0]);
      prefix_armed = 1'b0;
      if (code[7]) keys = keys & ~bit_v;
      else keys = keys | bit_v;
    endfunction

    function void note_command(cmd_t cmd, logic [7:0] code);
      key_report_t rep;
      rep.pop_valid = 1'b0;
      rep.pop_code = '0;
      case (cmd)
        CMD_SUBMIT: begin
          take_scancode(code);
          rep.exit_flag = exit_latch;
        end
        CMD_POP: begin
          if (rd_ptr != wr_ptr) begin
            rep.pop_valid = 1'b1;
            rep.pop_code = ring[rd_ptr];
            rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH_DEF;
          end
          rep.exit_flag = exit_latch;
        end
        CMD_READ_EXIT: begin
          rep.exit_flag = exit_latch;
          exit_latch = 1'b0;
        end
        default: begin
          exit_latch = 1'b1;
          rep.exit_flag = exit_latch;
        end
      endcase
      rep.held_keys = keys;
      expected_reports.push_back(rep);
    endfunction

    function void check_result(logic [5:0] held_keys, logic pop_valid,
                               logic [7:0] pop_code, logic exit_flag);
      key_report_t exp_rep;
      if (expected_reports.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      exp_rep = expected_reports.pop_front();
      if (held_keys !== exp_rep.held_keys) begin
        $error("held_keys: expected %h actual %h", exp_rep.held_keys, held_keys);
        errors++;
      end
      if (pop_valid !== exp_rep.pop_valid) begin
        $error("pop_valid: expected %b actual %b", exp_rep.pop_valid, pop_valid);
        errors++;
      end
      if (pop_code !== exp_rep.pop_code) begin
        $error("pop_code: expected %h actual %h", exp_rep.pop_code, pop_code);
        errors++;
      end
      if (exit_flag !== exp_rep.exit_flag) begin
        $error("exit_flag: expected %b actual %b", exp_rep.exit_flag, exit_flag);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== verif/tb_scancode_key_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_scancode_key_tracker
// drives scancodes and commands into the key tracker under random stalls on
// both channels, predicts every result and checks it field by field
// ----------------------------------------------------------------------------
module tb_scancode_key_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;
  import skt_scoreboard_pkg::*;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned LONG_HOLD  = 150;
  localparam int unsigned PHASE_LEN  = 230;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        hold_req;
  logic        quiet;
  int unsigned sent;

  tracker_scoreboard sb = new();

  skt_in_if  in_if();
  skt_out_if out_if();

  scancode_key_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [6:0] main_code_at(int unsigned k);
    case (k)
      0:       return SC_MAIN_W;
      1:       return SC_MAIN_S;
      2:       return SC_MAIN_A;
      3:       return SC_MAIN_D;
      4:       return SC_MAIN_Q;
      default: return SC_MAIN_E;
    endcase
  endfunction

  function automatic logic [6:0] ext_code_at(int unsigned k);
    case (k)
      0:       return SC_EXT_W;
      1:       return SC_EXT_S;
      2:       return SC_EXT_Q;
      default: return SC_EXT_E;
    endcase
  endfunction

  task automatic send_command(cmd_t cmd, logic [7:0] code);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.scancode <= code;
    do @(posedge clk); while (!in_if.ready);
    sb.note_command(cmd, code);
    sent++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(logic value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_enable(value);
  endtask

  task automatic send_key_event();
    logic rel;
    rel = $urandom_range(0, 1);
    if ($urandom_range(0, 2) == 0) begin
      send_command(CMD_SUBMIT, SC_PREFIX);
      send_command(CMD_SUBMIT, {rel, ext_code_at($urandom_range(0, 3))});
    end else begin
      send_command(CMD_SUBMIT, {rel, main_code_at($urandom_range(0, 5))});
    end
  endtask

  task automatic send_random_item(int unsigned pop_pct);
    int unsigned r;
    if ($urandom_range(0, 99) < pop_pct) begin
      send_command(CMD_POP, 8'($urandom_range(0, 255)));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 50) send_key_event();
    else if (r < 65) send_command(CMD_SUBMIT, 8'($urandom_range(0, 255)));
    else if (r < 69) send_command(CMD_SUBMIT, {1'($urandom_range(0, 1)), SC_ESC});
    else if (r < 72) send_command(CMD_SUBMIT, SC_PREFIX);
    else if (r < 86) send_command(CMD_READ_EXIT, 8'($urandom_range(0, 255)));
    else if (r < 92) send_command(CMD_SET_EXIT, 8'($urandom_range(0, 255)));
    else send_command(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // result sink with random stalls and one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.held_keys, out_if.pop_valid, out_if.pop_code, out_if.exit_flag);
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned pop_pct;
    int unsigned target;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.cmd <= CMD_SUBMIT;
    in_if.scancode <= '0;
    hold_req = 1'b0;
    quiet = 1'b0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset: submit ignored, empty pop, exit flag commands
    send_command(CMD_SUBMIT, {1'b0, SC_MAIN_W});
    send_command(CMD_POP, 8'h00);
    send_command(CMD_SET_EXIT, 8'hFF);
    send_command(CMD_READ_EXIT, 8'h00);
    send_command(CMD_READ_EXIT, 8'h00);

    write_enable(1'b1);
    send_command(CMD_SUBMIT, {1'b0, SC_MAIN_W});
    send_command(CMD_SUBMIT, {1'b0, SC_MAIN_S});
    send_command(CMD_SUBMIT, {1'b0, SC_MAIN_A});
    send_command(CMD_SUBMIT, {1'b0, SC_MAIN_D});
    send_command(CMD_SUBMIT, {1'b0, SC_MAIN_Q});
    send_command(CMD_SUBMIT, {1'b0, SC_MAIN_E});
    send_command(CMD_SUBMIT, {1'b1, SC_MAIN_W});
    send_command(CMD_SUBMIT, SC_PREFIX);
    send_command(CMD_SUBMIT, SC_PREFIX);
    send_command(CMD_SUBMIT, {1'b1, SC_EXT_S});
    send_command(CMD_SUBMIT, SC_PREFIX);
    send_command(CMD_SUBMIT, {1'b0, SC_EXT_W});
    send_command(CMD_SUBMIT, SC_PREFIX);
    send_command(CMD_SUBMIT, {1'b0, SC_ESC});
    send_command(CMD_READ_EXIT, 8'h00);
    send_command(CMD_SUBMIT, {1'b1, SC_ESC});
    send_command(CMD_SUBMIT, 8'h00);
    send_command(CMD_SUBMIT, 8'hFF);
    send_command(CMD_POP, 8'h00);
    send_command(CMD_POP, 8'hFF);
    send_command(CMD_READ_EXIT, 8'h00);
    send_command(CMD_SET_EXIT, 8'h00);
    send_command(CMD_READ_EXIT, 8'h00);

    for (int ph = 0; ph < 6; ph++) begin
      write_enable(ph != 2);
      case (ph)
        1:       pop_pct = 5;
        3:       pop_pct = 60;
        4:       pop_pct = 20;
        default: pop_pct = 30;
      endcase
      quiet = (ph == 4);
      if (ph == 1) hold_req = 1'b1;
      target = sent + PHASE_LEN;
      while (sent < target) send_random_item(pop_pct);
    end
    quiet = 1'b0;

    settle();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
